FILE: sv/nsc_pkg.sv
package nsc_pkg;

  // ASCII codes the parser reacts to.
  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperC  = 8'h43;
  localparam logic [7:0] ChUpperG  = 8'h47;
  localparam logic [7:0] ChUpperM  = 8'h4D;
  localparam logic [7:0] ChUpperR  = 8'h52;

  // Configuration register indexes.
  localparam logic CfgGgaFixField    = 1'b0;
  localparam logic CfgRmcStatusField = 1'b1;

  localparam logic [3:0] GgaFixReset    = 4'd6;
  localparam logic [3:0] RmcStatusReset = 4'd2;

  // Class of a received byte, decided in the front part.
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_DOLLAR,
    CLS_NEWLINE,
    CLS_STAR,
    CLS_COMMA
  } byte_class_e;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_GGA   = 2'd1,
    KIND_RMC   = 2'd2
  } sentence_kind_e;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    logic [7:0]  data;
    byte_class_e cls;
  } byte_word_t;

  // Queue status reported by the queue to the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef struct packed {
    logic [3:0] gga_fix_field;
    logic [3:0] rmc_status_field;
  } cfg_t;

  // Upper-case hex digit for the low nibble of its argument.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = ChZero + {4'd0, nib};
    end else begin
      ch = ChUpperA + {4'd0, nib} - 8'd10;
    end
    return ch;
  endfunction

  function automatic byte_class_e classify(input logic [7:0] b);
    byte_class_e c;
    case (b)
      ChDollar:  c = CLS_DOLLAR;
      ChNewline: c = CLS_NEWLINE;
      ChStar:    c = CLS_STAR;
      ChComma:   c = CLS_COMMA;
      default:   c = CLS_OTHER;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/nsc_if.sv
// Byte channel into the checker.
interface nsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
  modport mon    (input valid, input rx_byte, input ready);
endinterface

// Result channel out of the checker.
interface nsc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] sentence_kind;
  logic       checksum_good;
  logic [7:0] captured_char;
  logic       position_valid;
  logic [7:0] computed_sum;

  modport source (output valid, output sentence_kind, output checksum_good,
                  output captured_char, output position_valid, output computed_sum,
                  input ready);
  modport sink   (input valid, input sentence_kind, input checksum_good,
                  input captured_char, input position_valid, input computed_sum,
                  output ready);
  modport mon    (input valid, input sentence_kind, input checksum_good,
                  input captured_char, input position_valid, input computed_sum,
                  input ready);
endinterface

FILE: sv/nmea_sentence_checker_top.sv
// NMEA sentence checker. One received byte is accepted per cycle on rx_i while
// the queue has room, and a result word appears on res_o for each newline that
// ends a sentence: sentence kind, checksum verdict, the captured GGA fix or RMC
// status character, a position-valid flag and the computed XOR sum. A byte
// passes the classify register and then the queue before the parser takes it,
// and the parser loads the result register at the edge at which it takes the
// newline. The sustained rate is one byte per cycle while no result word is
// stalled on res_o.
// A result waiting on res_o stalls only the parser; the queue of Depth words
// and the classify stage keep taking bytes until they fill. Depth must be a
// power of two. Configuration should be written only while no sentence is in
// flight, because a write takes effect at once.
module nmea_sentence_checker_top
  import nsc_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  nsc_byte_if.sink   rx_i,
  nsc_res_if.source  res_o
);

  fifo_status_t fifo_status;
  logic         push, pop;
  byte_word_t   push_word, pop_word;

  nsc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_i          (rx_i),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .word_o        (push_word)
  );

  nsc_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .word_i   (push_word),
    .pop_i    (pop),
    .word_o   (pop_word),
    .status_o (fifo_status)
  );

  nsc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .empty_i    (fifo_status.empty),
    .word_i     (pop_word),
    .pop_o      (pop),
    .res_o      (res_o)
  );

endmodule

FILE: sv/nsc_front.sv
module nsc_front
  import nsc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  nsc_byte_if.sink     rx_i,
  input  fifo_status_t fifo_status_i,
  output logic         push_o,
  output byte_word_t   word_o
);

  logic       stage_valid_q;
  byte_word_t stage_word_q;

  // The stage pushes its byte whenever it holds one and the queue has room.
  assign push_o     = stage_valid_q && !fifo_status_i.full;
  assign word_o     = stage_word_q;
  assign rx_i.ready = !stage_valid_q || !fifo_status_i.full;

  // Control of the classify stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      stage_valid_q <= rx_i.valid;
    end
  end

  // Classified word; loaded with every accepted byte.
  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      stage_word_q.data <= rx_i.rx_byte;
      stage_word_q.cls  <= classify(rx_i.rx_byte);
    end
  end

endmodule

FILE: sv/nsc_fifo.sv
module nsc_fifo
  import nsc_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  byte_word_t   word_i,
  input  logic         pop_i,
  output byte_word_t   word_o,
  output fifo_status_t status_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  byte_word_t           mem_q [Depth];
  logic [AddrW:0]       wptr_q, rptr_q;
  logic [AddrW-1:0]     waddr, raddr;

  assign waddr = wptr_q[AddrW-1:0];
  assign raddr = rptr_q[AddrW-1:0];

  assign status_o.empty = (wptr_q == rptr_q);
  assign status_o.full  = (wptr_q[AddrW] != rptr_q[AddrW]) && (waddr == raddr);
  assign word_o         = mem_q[raddr];

  // Pointers wrap with one extra bit to tell full from empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[waddr] <= word_i;
    end
  end

endmodule

FILE: sv/nsc_back.sv
module nsc_back
  import nsc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [3:0]   cfg_data_i,
  input  logic         empty_i,
  input  byte_word_t   word_i,
  output logic         pop_o,
  nsc_res_if.source    res_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BODY,
    PH_SUM
  } phase_e;

  cfg_t       cfg_q;
  phase_e     phase_q, phase_d;
  logic [7:0] xor_q, xor_d;
  logic [2:0] pos_q, pos_d;
  logic [1:0] km_q, km_d;
  logic [3:0] fc_q, fc_d;
  logic [7:0] held_gga_q, held_gga_d;
  logic [7:0] held_rmc_q, held_rmc_d;
  logic       gga_got_q, gga_got_d;
  logic       rmc_got_q, rmc_got_d;
  logic       afs_q, afs_d;
  logic       fdo_q, fdo_d;
  logic       dok_q, dok_d;

  logic       out_valid_q, out_valid_d;
  logic [1:0] kind_q, kind_d;
  logic       good_q, good_d;
  logic [7:0] cap_q, cap_d;
  logic       pvalid_q, pvalid_d;
  logic [7:0] sum_q, sum_d;
  logic       emit;

  logic [2:0]     body_pos;
  logic [7:0]     b;
  sentence_kind_e kind;

  // A byte is taken whenever a result slot is free or being drained.
  assign pop_o = !empty_i && (!out_valid_q || res_o.ready);
  assign b     = word_i.data;

  assign res_o.valid          = out_valid_q;
  assign res_o.sentence_kind  = kind_q;
  assign res_o.checksum_good  = good_q;
  assign res_o.captured_char  = cap_q;
  assign res_o.position_valid = pvalid_q;
  assign res_o.computed_sum   = sum_q;

  assign body_pos = (pos_q == 3'd7) ? 3'd7 : pos_q + 3'd1;

  // Sentence kind as it stands when the sentence ends.
  always_comb begin
    if (phase_q == PH_BODY && pos_q < 3'd5) begin
      kind = KIND_OTHER;
    end else if (km_q[0]) begin
      kind = KIND_GGA;
    end else if (km_q[1]) begin
      kind = KIND_RMC;
    end else begin
      kind = KIND_OTHER;
    end
  end

  // Parser next state.
  always_comb begin
    phase_d    = phase_q;
    xor_d      = xor_q;
    pos_d      = pos_q;
    km_d       = km_q;
    fc_d       = fc_q;
    held_gga_d = held_gga_q;
    held_rmc_d = held_rmc_q;
    gga_got_d  = gga_got_q;
    rmc_got_d  = rmc_got_q;
    afs_d      = afs_q;
    fdo_d      = fdo_q;
    dok_d      = dok_q;
    emit       = 1'b0;
    kind_d     = kind_q;
    good_d     = good_q;
    cap_d      = cap_q;
    pvalid_d   = pvalid_q;
    sum_d      = sum_q;

    if (pop_o) begin
      if (word_i.cls == CLS_DOLLAR) begin
        phase_d    = PH_BODY;
        xor_d      = '0;
        pos_d      = '0;
        km_d       = 2'b11;
        fc_d       = '0;
        held_gga_d = '0;
        held_rmc_d = '0;
        gga_got_d  = 1'b0;
        rmc_got_d  = 1'b0;
        afs_d      = 1'b1;
        fdo_d      = 1'b0;
        dok_d      = 1'b0;
      end else if (phase_q != PH_IDLE) begin
        if (word_i.cls == CLS_NEWLINE) begin
          emit     = 1'b1;
          kind_d   = kind;
          good_d   = (phase_q == PH_SUM) && dok_q;
          sum_d    = xor_q;
          cap_d    = '0;
          pvalid_d = 1'b0;
          if (kind == KIND_GGA) begin
            cap_d    = held_gga_q;
            pvalid_d = (held_gga_q != 8'd0) && (held_gga_q != ChZero);
          end else if (kind == KIND_RMC) begin
            cap_d    = held_rmc_q;
            pvalid_d = (held_rmc_q == ChUpperA);
          end
          phase_d = PH_IDLE;
        end else if (phase_q == PH_BODY) begin
          if (word_i.cls == CLS_STAR) begin
            if (pos_q < 3'd5) begin
              km_d = 2'b00;
            end
            pos_d   = '0;
            phase_d = PH_SUM;
          end else begin
            xor_d = xor_q ^ b;
            pos_d = body_pos;
            // Name letters three to five select GGA or RMC.
            case (body_pos)
              3'd3: begin
                if (b != ChUpperG) km_d[0] = 1'b0;
                if (b != ChUpperR) km_d[1] = 1'b0;
              end
              3'd4: begin
                if (b != ChUpperG) km_d[0] = 1'b0;
                if (b != ChUpperM) km_d[1] = 1'b0;
              end
              3'd5: begin
                if (b != ChUpperA) km_d[0] = 1'b0;
                if (b != ChUpperC) km_d[1] = 1'b0;
              end
              default: begin
              end
            endcase
            // Capture the first character of the selected fields.
            if (afs_q) begin
              if (fc_q == cfg_q.gga_fix_field && !gga_got_q) begin
                gga_got_d = 1'b1;
                if (word_i.cls != CLS_COMMA) held_gga_d = b;
              end
              if (fc_q == cfg_q.rmc_status_field && !rmc_got_q) begin
                rmc_got_d = 1'b1;
                if (word_i.cls != CLS_COMMA) held_rmc_d = b;
              end
              afs_d = 1'b0;
            end
            if (word_i.cls == CLS_COMMA) begin
              if (fc_q != 4'd15) fc_d = fc_q + 4'd1;
              afs_d = 1'b1;
            end
          end
        end else begin
          // Two checksum digits after the star, then ignore until newline.
          if (pos_q == 3'd0) begin
            fdo_d = (b == hex_char(xor_q[7:4]));
            pos_d = 3'd1;
          end else if (pos_q == 3'd1) begin
            dok_d = fdo_q && (b == hex_char(xor_q[3:0]));
            pos_d = 3'd2;
          end
        end
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Parser state, configuration and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gga_fix_field    <= GgaFixReset;
      cfg_q.rmc_status_field <= RmcStatusReset;
      phase_q     <= PH_IDLE;
      xor_q       <= '0;
      pos_q       <= '0;
      km_q        <= 2'b11;
      fc_q        <= '0;
      held_gga_q  <= '0;
      held_rmc_q  <= '0;
      gga_got_q   <= 1'b0;
      rmc_got_q   <= 1'b0;
      afs_q       <= 1'b0;
      fdo_q       <= 1'b0;
      dok_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgGgaFixField:    cfg_q.gga_fix_field    <= cfg_data_i;
          CfgRmcStatusField: cfg_q.rmc_status_field <= cfg_data_i;
          default: begin
          end
        endcase
      end
      phase_q     <= phase_d;
      xor_q       <= xor_d;
      pos_q       <= pos_d;
      km_q        <= km_d;
      fc_q        <= fc_d;
      held_gga_q  <= held_gga_d;
      held_rmc_q  <= held_rmc_d;
      gga_got_q   <= gga_got_d;
      rmc_got_q   <= rmc_got_d;
      afs_q       <= afs_d;
      fdo_q       <= fdo_d;
      dok_q       <= dok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    good_q   <= good_d;
    cap_q    <= cap_d;
    pvalid_q <= pvalid_d;
    sum_q    <= sum_d;
  end

endmodule

FILE: sv/nsc_checker.sv
module nsc_checker
  import nsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       res_valid_i,
  input  logic       res_ready_i,
  input  logic [1:0] res_kind_i,
  input  logic       res_good_i,
  input  logic [7:0] res_cap_i,
  input  logic       res_pvalid_i,
  input  logic [7:0] res_sum_i
);

  // A stalled result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its checksum verdict and sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_sum_i) && $stable(res_good_i))
    else $error("result word changed while stalled");

  // The kind code never takes the unused value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_kind_i != 2'd3)
    else $error("illegal sentence kind");

  // Other sentences carry no captured character and no valid position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_kind_i == KIND_OTHER
      |-> res_cap_i == 8'd0 && !res_pvalid_i)
    else $error("capture on other sentence");

  // A valid position needs a captured character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_pvalid_i |-> res_cap_i != 8'd0)
    else $error("position valid without captured character");

endmodule

bind nmea_sentence_checker_top nsc_checker u_nsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_kind_i   (res_o.sentence_kind),
  .res_good_i   (res_o.checksum_good),
  .res_cap_i    (res_o.captured_char),
  .res_pvalid_i (res_o.position_valid),
  .res_sum_i    (res_o.computed_sum)
);
